>>> src/hcsf_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// chunked stream framer. No dependencies.
`timescale 1ns / 1ps

package hcsf_pkg;

  // Buffer and beat geometry
  localparam int BUFFER_BYTES = 512;
  localparam int BEAT_BYTES   = 16;

  // Fixed field widths
  localparam int CFG_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int HALF_W     = 64;
  localparam int BEAT_CNT_W = 5;
  localparam int OUT_LANES  = 16;
  localparam int LANE_W     = 4;

  // Derived widths
  localparam int CNT_W      = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W     = $clog2(BUFFER_BYTES);
  localparam int HEX_DIGITS = (CNT_W + 3) / 4;
  localparam int HEX_PAD_W  = HEX_DIGITS * 4;
  localparam int HL_W       = $clog2(HEX_DIGITS + 1);
  localparam int TOTAL_MAX  = HEX_DIGITS + 4 + BUFFER_BYTES;
  localparam int POS_W      = $clog2(TOTAL_MAX + 1);

  localparam logic [CFG_W-1:0] CHUNK_SIZE_RESET = CFG_W'(512);

  // Input command codes
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Framing characters
  localparam logic [BYTE_W-1:0] ASCII_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] ASCII_LF = 8'h0A;

  // Controller to datapath
  typedef struct packed {
    logic idle;    // input channel open
    logic read;    // fetch buffer byte for the current position
    logic append;  // place the current stream byte into the beat
    logic send;    // move the finished beat to the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_chunk;  // offered item begins a chunk
    logic empty_flush;  // offered item is a flush with nothing buffered
    logic beat_done;    // byte being appended closes the beat
    logic last;         // beat in assembly ends the chunk
    logic out_free;     // output register can take a beat this cycle
  } ctrl_stat_t;

endpackage

>>> src/hcsf_if.sv
// Channel interfaces of the chunked stream framer: input items, output beats
// and the chunk size write channel. Depends on hcsf_pkg.
`timescale 1ns / 1ps

interface hcsf_in_if
  import hcsf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] payload_byte;

  modport source (output valid, output cmd, output payload_byte, input ready);
  modport sink   (input valid, input cmd, input payload_byte, output ready);
endinterface

interface hcsf_out_if
  import hcsf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [HALF_W-1:0]     beat_low;
  logic [HALF_W-1:0]     beat_high;
  logic [BEAT_CNT_W-1:0] beat_bytes;
  logic                  chunk_end;
  logic                  flush_request;

  modport source (output valid, output beat_low, output beat_high, output beat_bytes,
                  output chunk_end, output flush_request, input ready);
  modport sink   (input valid, input beat_low, input beat_high, input beat_bytes,
                  input chunk_end, input flush_request, output ready);
endinterface

interface hcsf_cfg_if
  import hcsf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] chunk_size;

  modport source (output valid, output chunk_size, input ready);
  modport sink   (input valid, input chunk_size, output ready);
endinterface

>>> src/http_chunked_stream_framer_top.sv
// Top level of the HTTP chunked stream framer: controller plus datapath.
// Depends on hcsf_pkg, hcsf_if, hcsf_ctrl and hcsf_dp.
`timescale 1ns / 1ps
//
//  Port    Dir   Transaction                 Payload
//  in_i    sink  one payload byte or flush   cmd, payload_byte
//  out_o   src   one beat of encoded stream  beat_low, beat_high, beat_bytes,
//                                            chunk_end, flush_request
//  cfg_i   sink  chunk size write            chunk_size (always ready)
//
//  A payload byte that leaves the buffer short of the chunk size is stored
//  and in_i stays ready. A transaction that emits a chunk of n bytes with
//  an h digit length runs T = h + 4 + n encoded bytes through the beat
//  assembler, each byte as a buffer memory read, then a lane write, and each
//  beat as a send to the output register; in_i stays not ready meanwhile.
//  An empty flush sends an empty beat. Reset clears the fill count, restores a
//  chunk size of 512 and empties the output register; the buffer needs no
//  clearing pass. A stalled out_o holds the beat assembler at its next beat,
//  while one finished beat waits in the output register.

module http_chunked_stream_framer_top
  import hcsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  hcsf_in_if.sink    in_i,
  hcsf_out_if.source out_o,
  hcsf_cfg_if.sink   cfg_i
);

  ctrl_cmd_t  ctrl_cmd;
  ctrl_stat_t ctrl_stat;

  // Sequencer: idle, read, append, send
  hcsf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (ctrl_stat),
    .cmd_o  (ctrl_cmd)
  );

  // Buffer, framing and beat datapath
  hcsf_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (ctrl_cmd),
    .stat_o (ctrl_stat)
  );

endmodule

>>> src/hcsf_ctrl.sv
// Sequencing state machine of the chunked stream framer.
// Depends on hcsf_pkg for the command and status structs.
`timescale 1ns / 1ps

module hcsf_ctrl
  import hcsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_APPEND = 4'b0100,
    ST_SEND   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (stat_i.start_chunk) begin
          state_d = ST_READ;
        end else if (stat_i.empty_flush) begin
          state_d = ST_SEND;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_APPEND;
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = stat_i.beat_done ? ST_SEND : ST_READ;
      end
      ST_SEND: begin
        cmd_o.send = 1'b1;
        // hold until the output register frees up
        if (stat_i.out_free) begin
          state_d = stat_i.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/hcsf_dp.sv
// Datapath of the chunked stream framer: chunk buffer memory, fill count,
// chunk size register, stream byte selection, beat assembly, output register.
// Depends on hcsf_pkg and the channel interfaces in hcsf_if.
`timescale 1ns / 1ps

module hcsf_dp
  import hcsf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  hcsf_in_if.sink         in_i,
  hcsf_out_if.source      out_o,
  hcsf_cfg_if.sink        cfg_i,
  input  ctrl_cmd_t       cmd_i,
  output ctrl_stat_t      stat_o
);

  logic [BYTE_W-1:0] store_mem [BUFFER_BYTES];

  logic [CNT_W-1:0]            fill_q;
  logic [CFG_W-1:0]            chunk_size_q;
  logic [CNT_W-1:0]            n_q;
  logic [POS_W-1:0]            pos_q;
  logic                        flush_q;
  logic                        last_q;
  logic [BYTE_W-1:0]           rdata_q;
  logic [OUT_LANES*BYTE_W-1:0] beat_q;
  logic [BEAT_CNT_W-1:0]       cnt_q;

  logic                        out_valid_q;
  logic [OUT_LANES*BYTE_W-1:0] out_beat_q;
  logic [BEAT_CNT_W-1:0]       out_bytes_q;
  logic                        out_end_q;
  logic                        out_flush_q;

  logic                  take;
  logic                  load_out;
  logic [CNT_W-1:0]      fill_inc;
  logic [CNT_W-1:0]      eff_size;
  logic                  chunk_due;
  logic [HEX_PAD_W-1:0]  n_pad;
  logic [HL_W-1:0]       hl_c;
  logic [HL_W-1:0]       dig_idx;
  logic [3:0]            digit;
  logic [BYTE_W-1:0]     hex_char;
  logic [POS_W-1:0]      hdr_end;
  logic [POS_W-1:0]      pay_end;
  logic [POS_W-1:0]      total_c;
  logic [POS_W-1:0]      pos_inc;
  logic [POS_W-1:0]      rd_off;
  logic [ADDR_W-1:0]     rd_addr;
  logic [BYTE_W-1:0]     stream_byte;
  logic [BEAT_CNT_W-1:0] cnt_inc;

  assign take        = in_i.valid & cmd_i.idle;
  assign in_i.ready  = cmd_i.idle;
  assign cfg_i.ready = 1'b1;

  // Effective chunk size: zero and oversize fall back to the buffer size
  always_comb begin
    if (chunk_size_q == '0 || 32'(chunk_size_q) > BUFFER_BYTES) begin
      eff_size = CNT_W'(BUFFER_BYTES);
    end else begin
      eff_size = CNT_W'(chunk_size_q);
    end
  end

  assign fill_inc  = fill_q + 1'b1;
  assign chunk_due = fill_inc >= eff_size;

  assign stat_o.start_chunk = in_i.valid &
                              (((in_i.cmd == CMD_BYTE) & chunk_due) |
                               ((in_i.cmd == CMD_FLUSH) & (fill_q != '0)));
  assign stat_o.empty_flush = in_i.valid & (in_i.cmd == CMD_FLUSH) & (fill_q == '0);

  // Hex length of the chunk byte count, no leading zeros
  assign n_pad = HEX_PAD_W'(n_q);
  always_comb begin
    hl_c = HL_W'(1);
    for (int d = 1; d < HEX_DIGITS; d++) begin
      if (n_pad[4*d +: 4] != 4'd0) begin
        hl_c = HL_W'(d + 1);
      end
    end
  end

  // Most significant digit goes out first
  assign dig_idx = HL_W'(hl_c - HL_W'(1) - HL_W'(pos_q));
  always_comb begin
    digit = 4'd0;
    for (int d = 0; d < HEX_DIGITS; d++) begin
      if (dig_idx == HL_W'(d)) begin
        digit = n_pad[4*d +: 4];
      end
    end
  end
  assign hex_char = (digit < 4'd10) ? (8'h30 + BYTE_W'(digit)) : (8'h37 + BYTE_W'(digit));

  assign hdr_end = POS_W'(hl_c) + POS_W'(2);
  assign pay_end = hdr_end + POS_W'(n_q);
  assign total_c = pay_end + POS_W'(2);
  assign pos_inc = pos_q + 1'b1;
  assign rd_off  = pos_q - hdr_end;
  assign rd_addr = rd_off[ADDR_W-1:0];
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    priority if (pos_q < POS_W'(hl_c)) begin
      stream_byte = hex_char;
    end else if (pos_q == POS_W'(hl_c)) begin
      stream_byte = ASCII_CR;
    end else if (pos_q < hdr_end) begin
      stream_byte = ASCII_LF;
    end else if (pos_q < pay_end) begin
      stream_byte = rdata_q;
    end else if (pos_q == pay_end) begin
      stream_byte = ASCII_CR;
    end else begin
      stream_byte = ASCII_LF;
    end
  end

  assign stat_o.beat_done = (cnt_inc == BEAT_CNT_W'(BEAT_BYTES)) || (pos_inc == total_c);
  assign stat_o.last      = last_q;
  assign stat_o.out_free  = ~out_valid_q | out_o.ready;
  assign load_out         = cmd_i.send & stat_o.out_free;

  // Chunk buffer
  always_ff @(posedge clk_i) begin
    if (take && in_i.cmd == CMD_BYTE && 32'(fill_q) < BUFFER_BYTES) begin
      store_mem[fill_q[ADDR_W-1:0]] <= in_i.payload_byte;
    end
    if (cmd_i.read) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  // Fill count and chunk size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      chunk_size_q <= CHUNK_SIZE_RESET;
    end else begin
      if (cfg_i.valid) begin
        chunk_size_q <= cfg_i.chunk_size;
      end
      if (take) begin
        if (in_i.cmd == CMD_BYTE && !chunk_due) begin
          fill_q <= fill_inc;
        end else begin
          fill_q <= '0;
        end
      end
    end
  end

  // Chunk sequencing and beat assembly
  always_ff @(posedge clk_i) begin
    if (take) begin
      n_q     <= (in_i.cmd == CMD_BYTE) ? fill_inc : fill_q;
      flush_q <= (in_i.cmd == CMD_FLUSH);
      last_q  <= (in_i.cmd == CMD_FLUSH) && (fill_q == '0);
      pos_q   <= '0;
      cnt_q   <= '0;
      beat_q  <= '0;
    end else if (cmd_i.append) begin
      beat_q[BYTE_W*cnt_q[LANE_W-1:0] +: BYTE_W] <= stream_byte;
      cnt_q  <= cnt_inc;
      pos_q  <= pos_inc;
      last_q <= (pos_inc == total_c);
    end else if (load_out) begin
      beat_q <= '0;
      cnt_q  <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_beat_q  <= beat_q;
      out_bytes_q <= cnt_q;
      out_end_q   <= last_q;
      out_flush_q <= last_q & flush_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.beat_low      = out_beat_q[HALF_W-1:0];
  assign out_o.beat_high     = out_beat_q[2*HALF_W-1:HALF_W];
  assign out_o.beat_bytes    = out_bytes_q;
  assign out_o.chunk_end     = out_end_q;
  assign out_o.flush_request = out_flush_q;

endmodule

>>> tb/sv/http_chunked_stream_framer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for http_chunked_stream_framer_top: payload bytes, flushes
// and chunk size writes go in, every output beat is checked against a built-in
// chunk encoder. Depends on hcsf_pkg, hcsf_if and the framer RTL.

module http_chunked_stream_framer_top_tb;
  import hcsf_pkg::*;

  // Quiet cycles (no transaction on any channel) before the run is declared hung.
  // The slowest legitimate gap is the long output hold-off plus the first beat
  // of a chunk, well under this.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_PCT       = 21;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;
  localparam int NUM_ROWS       = 27;
  localparam int NUM_PHASES     = 9;

  // Random phases with a special role.
  localparam int HOLD_PHASE        = 0;
  localparam int STEADY_PHASE      = 1;
  localparam int PAUSE_PHASE       = 2;
  localparam int RANDOM_SIZE_PHASE = 7;

  typedef struct packed {
    logic [HALF_W-1:0]     beat_low;
    logic [HALF_W-1:0]     beat_high;
    logic [BEAT_CNT_W-1:0] beat_bytes;
    logic                  chunk_end;
    logic                  flush_request;
  } chunk_beat_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              cmd;
    logic [BYTE_W-1:0] data;
    logic [CFG_W-1:0]  size;
    logic              typed;  // beat below is the hand-written answer
    chunk_beat_t       beat;
  } stim_row_t;

  typedef struct packed {
    logic        typed;
    chunk_beat_t beat;
  } hand_check_t;

  localparam chunk_beat_t NO_BEAT          = '0;
  localparam chunk_beat_t EMPTY_FLUSH_BEAT = '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1};
  // "2" CR LF 00 FF CR LF, closed by the flush
  localparam chunk_beat_t PAIR_FLUSH_BEAT  =
    '{64'h000A_0DFF_000A_0D32, 64'h0, 5'd7, 1'b1, 1'b1};
  // "1" CR LF FF CR LF and "1" CR LF 00 CR LF at a chunk size of one
  localparam chunk_beat_t ONE_FF_BEAT      =
    '{64'h0000_0A0D_FF0A_0D31, 64'h0, 5'd6, 1'b1, 1'b0};
  localparam chunk_beat_t ONE_00_BEAT      =
    '{64'h0000_0A0D_000A_0D31, 64'h0, 5'd6, 1'b1, 1'b0};

  // Directed table: empty flush after reset, partial flush, single-byte chunks,
  // a two-beat chunk with a letter in its hex length, saturated size, and a
  // size lowered below the current fill.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_ITEM, CMD_FLUSH, 8'h00, 10'd0,    1'b1, EMPTY_FLUSH_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h00, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'hFF, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_FLUSH, 8'h00, 10'd0,    1'b1, PAIR_FLUSH_BEAT},
    '{ROW_CFG,  CMD_BYTE,  8'h00, 10'd1,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'hFF, 10'd0,    1'b1, ONE_FF_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h00, 10'd0,    1'b1, ONE_00_BEAT},
    '{ROW_ITEM, CMD_FLUSH, 8'hA5, 10'd0,    1'b1, EMPTY_FLUSH_BEAT},
    '{ROW_CFG,  CMD_BYTE,  8'h00, 10'd12,   1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h00, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'hFF, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h55, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'hAA, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h01, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h80, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h7F, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'hFE, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h0F, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'hF0, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h33, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'hCC, 10'd0,    1'b0, NO_BEAT},
    '{ROW_CFG,  CMD_BYTE,  8'h00, 10'd1023, 1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h11, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h22, 10'd0,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h33, 10'd0,    1'b0, NO_BEAT},
    '{ROW_CFG,  CMD_BYTE,  8'h00, 10'd2,    1'b0, NO_BEAT},
    '{ROW_ITEM, CMD_BYTE,  8'h44, 10'd0,    1'b0, NO_BEAT}
  };

  // Random phases: chunk size, item count and flush share of each. The zero
  // and 1023 sizes both act as 512; the 1023 phase builds a long partial chunk
  // that its closing flush sends out over many beats.
  logic [CFG_W-1:0] phase_sizes [NUM_PHASES] =
    '{10'd1, 10'd5, 10'd14, 10'd0, 10'd2, 10'd1023, 10'd33, 10'd1, 10'd512};
  int phase_items     [NUM_PHASES] = '{27, 27, 27, 27, 27, 120, 27, 27, 27};
  int phase_flush_pct [NUM_PHASES] = '{6, 6, 6, 25, 10, 0, 6, 6, 6};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hcsf_in_if  in_if ();
  hcsf_out_if out_if ();
  hcsf_cfg_if cfg_if ();

  http_chunked_stream_framer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // Encoder state mirrored from the block's point of view.
  logic [BYTE_W-1:0] chunk_buf [BUFFER_BYTES];
  int unsigned       chunk_fill     = 0;
  logic [CFG_W-1:0]  chunk_size_reg = CHUNK_SIZE_RESET;

  chunk_beat_t pending_beats [$];
  hand_check_t hand_checks [$];

  int  mismatches   = 0;
  int  items_seen   = 0;
  int  flushes_seen = 0;
  int  beats_seen   = 0;
  int  size_writes  = 0;
  int  quiet_cycles = 0;
  bit  steady       = 1'b0;
  bit  hold_go      = 1'b0;
  bit  hold_taken   = 1'b0;
  int  hold_left    = 0;

  // Build the encoded chunk (hex length, CR LF, payload, CR LF) and cut it into
  // beats; the last beat carries chunk_end and, for a flush, flush_request.
  function automatic void encode_chunk(int unsigned n, logic from_flush);
    logic [BYTE_W-1:0] stream [$];
    chunk_beat_t       b;
    logic [3:0]        digit;
    bit                leading;
    int unsigned       lane;
    leading = 1'b1;
    for (int sh = 28; sh >= 0; sh -= 4) begin
      digit = 4'((n >> sh) & 15);
      // drop leading zero digits, keep the units digit always
      if (digit != 4'd0 || !leading || sh == 0) begin
        // uppercase: 'A' - 10 is 8'h37
        stream.push_back(digit < 4'd10 ? 8'h30 + 8'(digit) : 8'h37 + 8'(digit));
        leading = 1'b0;
      end
    end
    stream.push_back(ASCII_CR);
    stream.push_back(ASCII_LF);
    for (int i = 0; i < n; i++) stream.push_back(chunk_buf[i]);
    stream.push_back(ASCII_CR);
    stream.push_back(ASCII_LF);
    for (int pos = 0; pos < stream.size(); pos += BEAT_BYTES) begin
      b = '0;
      for (lane = 0; lane < BEAT_BYTES && pos + lane < stream.size(); lane++) begin
        if (lane < 8) b.beat_low[8*lane +: 8] = stream[pos + lane];
        else          b.beat_high[8*(lane-8) +: 8] = stream[pos + lane];
      end
      b.beat_bytes    = BEAT_CNT_W'(lane);
      b.chunk_end     = (pos + BEAT_BYTES >= stream.size());
      b.flush_request = b.chunk_end & from_flush;
      pending_beats.push_back(b);
    end
  endfunction

  // Advance the encoder by one accepted transaction.
  function automatic void frame_item(logic cmd, logic [BYTE_W-1:0] data);
    int unsigned n;
    int unsigned target;
    // zero and oversize chunk sizes act as the full buffer
    target = (chunk_size_reg == 0 || chunk_size_reg > BUFFER_BYTES) ?
             BUFFER_BYTES : chunk_size_reg;
    if (cmd == CMD_BYTE) begin
      if (chunk_fill < BUFFER_BYTES) chunk_buf[chunk_fill] = data;
      chunk_fill++;
      // a size lowered below the fill releases everything held at once
      if (chunk_fill >= target) begin
        n = (chunk_fill > BUFFER_BYTES) ? BUFFER_BYTES : chunk_fill;
        chunk_fill = 0;
        encode_chunk(n, 1'b0);
      end
    end else if (chunk_fill > 0) begin
      n = chunk_fill;
      chunk_fill = 0;
      encode_chunk(n, 1'b1);
    end else begin
      pending_beats.push_back(EMPTY_FLUSH_BEAT);
    end
  endfunction

  // Monitor: sample every channel at the rising edge, predict on accepted
  // input, check each accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    chunk_beat_t want;
    hand_check_t note;
    int          depth_before;
    if (rst_ni) begin
      quiet_cycles++;
      if (cfg_if.valid && cfg_if.ready) begin
        chunk_size_reg = cfg_if.chunk_size;
        size_writes++;
        quiet_cycles = 0;
      end
      if (in_if.valid && in_if.ready) begin
        note         = hand_checks.pop_front();
        depth_before = pending_beats.size();
        frame_item(in_if.cmd, in_if.payload_byte);
        // swap in the hand-written beat where the table gives one
        if (note.typed) begin
          if (pending_beats.size() != depth_before + 1) begin
            $error("table row expects one beat, encoder gives %0d",
                   pending_beats.size() - depth_before);
            mismatches++;
          end else begin
            pending_beats[$] = note.beat;
          end
        end
        items_seen++;
        if (in_if.cmd == CMD_FLUSH) flushes_seen++;
        quiet_cycles = 0;
      end
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        beats_seen++;
        if (pending_beats.size() == 0) begin
          $error("unexpected beat: beat_bytes %0d, beat_low %h",
                 out_if.beat_bytes, out_if.beat_low);
          mismatches++;
        end else begin
          want = pending_beats.pop_front();
          if (out_if.beat_low !== want.beat_low) begin
            $error("beat_low: expected %h, got %h", want.beat_low, out_if.beat_low);
            mismatches++;
          end
          if (out_if.beat_high !== want.beat_high) begin
            $error("beat_high: expected %h, got %h", want.beat_high, out_if.beat_high);
            mismatches++;
          end
          if (out_if.beat_bytes !== want.beat_bytes) begin
            $error("beat_bytes: expected %0d, got %0d",
                   want.beat_bytes, out_if.beat_bytes);
            mismatches++;
          end
          if (out_if.chunk_end !== want.chunk_end) begin
            $error("chunk_end: expected %b, got %b", want.chunk_end, out_if.chunk_end);
            mismatches++;
          end
          if (out_if.flush_request !== want.flush_request) begin
            $error("flush_request: expected %b, got %b",
                   want.flush_request, out_if.flush_request);
            mismatches++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d beats outstanding",
                 quiet_cycles, pending_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, none in the steady phase, and one long
  // hold-off that lets the block fill up and stall its input.
  always @(negedge clk_i) begin
    if (hold_go && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (steady) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offer one transaction from a falling edge, with random gaps first, and
  // return at the rising edge that accepts it. Valid stays high afterwards so
  // back-to-back items need no extra edge.
  task automatic send_item(logic cmd, logic [BYTE_W-1:0] data, logic typed,
                           chunk_beat_t beat);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    hand_checks.push_back(hand_check_t'{typed, beat});
    in_if.valid        <= 1'b1;
    in_if.cmd          <= cmd;
    in_if.payload_byte <= data;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Drop valid and hold until every expected beat has arrived, then give a
  // byte that caused no beat time to finish.
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the chunk size only once the block is idle.
  task automatic write_chunk_size(logic [CFG_W-1:0] size);
    drain_results();
    cfg_if.valid      <= 1'b1;
    cfg_if.chunk_size <= size;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_BYTE;
    in_if.payload_byte = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.chunk_size  = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: walk the table.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_chunk_size(directed_rows[r].size);
      end else begin
        send_item(directed_rows[r].cmd, directed_rows[r].data,
                  directed_rows[r].typed, directed_rows[r].beat);
      end
    end

    // Random part: one chunk size per phase. The buffer is not flushed between
    // phases, so a smaller size often lands below the carried-over fill.
    phase_sizes[RANDOM_SIZE_PHASE] = CFG_W'($urandom_range(1, 64));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_chunk_size(phase_sizes[p]);
      steady = (p == STEADY_PHASE);
      if (p == HOLD_PHASE) hold_go = 1'b1;
      for (int i = 0; i < phase_items[p]; i++) begin
        // pause the sender mid-phase until the output has caught up
        if (p == PAUSE_PHASE && i == phase_items[p] / 2) drain_results();
        send_item($urandom_range(0, 99) < phase_flush_pct[p] ? CMD_FLUSH : CMD_BYTE,
                  8'($urandom_range(0, 255)), 1'b0, NO_BEAT);
      end
      if (phase_flush_pct[p] == 0) send_item(CMD_FLUSH, 8'h00, 1'b0, NO_BEAT);
    end
    steady = 1'b0;
    send_item(CMD_FLUSH, 8'h00, 1'b0, NO_BEAT);

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d transactions (%0d flushes), %0d beats, %0d chunk size writes;",
             items_seen, flushes_seen, beats_seen, size_writes);
    $display("sizes 1 to 512 plus zero and oversize, a long partial chunk, a long stall.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
